[design/vsps_pkg.sv]
// Package for the visual servo PD settle core: beat types, register indexes,
// saturation limits and settle thresholds. No dependencies.
`default_nettype none

package vsps_pkg;

    localparam int VEL_W  = 24;
    localparam int POS_W  = 16;
    localparam int GAIN_W = 18;
    localparam int ERR_W  = 17;
    localparam int PROD_W = GAIN_W + ERR_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int CNT_W  = 8;

    localparam logic signed [VEL_W-1:0] VEL_MAX     = 24'sh7FFFFF;
    localparam logic signed [VEL_W-1:0] VEL_MIN     = 24'sh800000;
    localparam logic signed [VEL_W-1:0] THR_FORWARD = 24'sd3145;
    localparam logic signed [VEL_W-1:0] THR_SIDE    = 24'sd5242;

    localparam logic [CNT_W-1:0] SETTLE_OMNI = 8'd101;
    localparam logic [CNT_W-1:0] SETTLE_DIFF = 8'd150;

    typedef enum logic [2:0] {
        REG_DRIVE_MODE     = 3'd0,
        REG_KP_FORWARD     = 3'd1,
        REG_KD_FORWARD     = 3'd2,
        REG_KP_SIDE        = 3'd3,
        REG_KD_SIDE        = 3'd4,
        REG_TARGET_FORWARD = 3'd5,
        REG_TARGET_SIDE    = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_side;
        logic signed [POS_W-1:0] pos_forward;
        logic                    target_ok;
        logic                    task_idle;
        logic                    clear_located;
    } in_beat_t;

    typedef struct packed {
        logic signed [VEL_W-1:0] vel_forward;
        logic signed [VEL_W-1:0] vel_lateral;
        logic signed [VEL_W-1:0] vel_rotate;
        logic                    located;
    } out_beat_t;

endpackage

`default_nettype wire

[design/visual_servo_pd_settle_core.sv]
// PD position controller with settle detection, APB register file and
// valid/ready beat channels. Depends on vsps_pkg.
// Path: an accepted beat fills the input register; its result fills the result register.
// Throughput: one beat per cycle unless m_ready stalls; the four 18x17 multiplies, sums
// and the settle counter all sit between the input register and the result register.
// Reset: synchronous active-low aresetn clears all but the beat data registers.
`default_nettype none

module visual_servo_pd_settle_core (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire vsps_pkg::in_beat_t s_data,
    output logic                   m_valid,
    input  wire                    m_ready,
    output vsps_pkg::out_beat_t    m_data,
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire  [4:0]             paddr,
    input  wire  [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);
    import vsps_pkg::*;

    logic                     drive_mode_reg;
    logic signed [GAIN_W-1:0] kp_forward_reg, kd_forward_reg, kp_side_reg, kd_side_reg;
    logic signed [POS_W-1:0]  target_forward_reg, target_side_reg;

    logic                     in_valid_reg;
    in_beat_t                 in_data_reg;
    logic                     out_valid_reg, out_valid_next;
    out_beat_t                out_data_reg, out_data_next;

    logic signed [ERR_W-1:0]  prev_err_forward_reg, prev_err_forward_next;
    logic signed [ERR_W-1:0]  prev_err_side_reg, prev_err_side_next;
    logic [CNT_W-1:0]         settle_count_reg, settle_count_next;
    logic                     located_reg, located_next;

    logic                     advance, has_result, cfg_write;
    cfg_reg_t                 cfg_sel;
    logic signed [ERR_W-1:0]  err_forward, err_side;
    logic signed [PROD_W-1:0] prod_kd_f, prod_kp_f, prod_kd_s, prod_kp_s;
    logic signed [SUM_W-1:0]  sum_f, sum_s;
    logic signed [VEL_W-1:0]  vel_f, vel_s, cmd_f, cmd_s;
    logic                     small_cmd;
    logic [CNT_W-1:0]         count_inc, limit;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = cfg_reg_t'(paddr[4:2]);

    always_comb begin
        prdata = '0;
        case (cfg_sel)
            REG_DRIVE_MODE:     prdata = {31'd0, drive_mode_reg};
            REG_KP_FORWARD:     prdata = 32'(kp_forward_reg);
            REG_KD_FORWARD:     prdata = 32'(kd_forward_reg);
            REG_KP_SIDE:        prdata = 32'(kp_side_reg);
            REG_KD_SIDE:        prdata = 32'(kd_side_reg);
            REG_TARGET_FORWARD: prdata = 32'(target_forward_reg);
            REG_TARGET_SIDE:    prdata = 32'(target_side_reg);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_mode_reg     <= 1'b0;
            kp_forward_reg     <= '0;
            kd_forward_reg     <= '0;
            kp_side_reg        <= '0;
            kd_side_reg        <= '0;
            target_forward_reg <= '0;
            target_side_reg    <= '0;
        end else if (cfg_write) begin
            case (cfg_sel)
                REG_DRIVE_MODE:     drive_mode_reg     <= pwdata[0];
                REG_KP_FORWARD:     kp_forward_reg     <= pwdata[GAIN_W-1:0];
                REG_KD_FORWARD:     kd_forward_reg     <= pwdata[GAIN_W-1:0];
                REG_KP_SIDE:        kp_side_reg        <= pwdata[GAIN_W-1:0];
                REG_KD_SIDE:        kd_side_reg        <= pwdata[GAIN_W-1:0];
                REG_TARGET_FORWARD: target_forward_reg <= pwdata[POS_W-1:0];
                REG_TARGET_SIDE:    target_side_reg    <= pwdata[POS_W-1:0];
                default:            ;
            endcase
        end
    end

    // advance the held beat when the result register is free or draining
    assign advance    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || advance;
    assign has_result = !in_data_reg.clear_located && in_data_reg.target_ok
                        && in_data_reg.task_idle;

    always_comb begin
        err_forward = ERR_W'(in_data_reg.pos_forward) - ERR_W'(target_forward_reg);
        err_side    = ERR_W'(in_data_reg.pos_side) - ERR_W'(target_side_reg);
        prod_kd_f   = kd_forward_reg * prev_err_forward_reg;
        prod_kp_f   = kp_forward_reg * err_forward;
        prod_kd_s   = kd_side_reg * prev_err_side_reg;
        prod_kp_s   = kp_side_reg * err_side;
        sum_f = $signed({prod_kd_f[PROD_W-1], prod_kd_f})
              + $signed({prod_kp_f[PROD_W-1], prod_kp_f});
        sum_s = $signed({prod_kd_s[PROD_W-1], prod_kd_s})
              + $signed({prod_kp_s[PROD_W-1], prod_kp_s});

        if (sum_f > VEL_MAX)      vel_f = VEL_MAX;
        else if (sum_f < VEL_MIN) vel_f = VEL_MIN;
        else                      vel_f = sum_f[VEL_W-1:0];
        if (sum_s > VEL_MAX)      vel_s = VEL_MAX;
        else if (sum_s < VEL_MIN) vel_s = VEL_MIN;
        else                      vel_s = sum_s[VEL_W-1:0];

        small_cmd = (vel_f <= THR_FORWARD) && (vel_f >= -THR_FORWARD)
                 && (vel_s <= THR_SIDE) && (vel_s >= -THR_SIDE);
        count_inc = settle_count_reg + CNT_W'(1);
        limit     = drive_mode_reg ? SETTLE_DIFF : SETTLE_OMNI;

        prev_err_forward_next = prev_err_forward_reg;
        prev_err_side_next    = prev_err_side_reg;
        settle_count_next     = settle_count_reg;
        located_next          = located_reg;

        if (advance && in_data_reg.clear_located) begin
            settle_count_next = '0;
            located_next      = 1'b0;
        end else if (advance && has_result && !located_reg) begin
            prev_err_forward_next = err_forward;
            prev_err_side_next    = err_side;
            if (!small_cmd) begin
                settle_count_next = '0;
            end else if (count_inc >= limit) begin
                settle_count_next = '0;
                located_next      = 1'b1;
            end else begin
                settle_count_next = count_inc;
            end
        end

        cmd_f = located_next ? '0 : vel_f;
        cmd_s = located_next ? '0 : vel_s;
        out_data_next.vel_forward = cmd_f;
        out_data_next.vel_lateral = drive_mode_reg ? '0 : cmd_s;
        out_data_next.vel_rotate  = drive_mode_reg ? cmd_s : '0;
        out_data_next.located     = located_next;

        if (advance && has_result) out_valid_next = 1'b1;
        else if (m_ready)          out_valid_next = 1'b0;
        else                       out_valid_next = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            prev_err_forward_reg <= '0;
            prev_err_side_reg    <= '0;
            settle_count_reg     <= '0;
            located_reg          <= 1'b0;
        end else begin
            in_valid_reg         <= s_valid || (in_valid_reg && !advance);
            out_valid_reg        <= out_valid_next;
            prev_err_forward_reg <= prev_err_forward_next;
            prev_err_side_reg    <= prev_err_side_next;
            settle_count_reg     <= settle_count_next;
            located_reg          <= located_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance && has_result) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire
